/* sv/round_robin_delay_task_scheduler_core_assert.svh */
// Assertion macros for the round-robin delay task scheduler.
`ifndef ROUND_ROBIN_DELAY_TASK_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_DELAY_TASK_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// ante true at an edge implies cons at the next edge
`define RRDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
// ante true implies cons in the same cycle
`define RRDS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`else
`define RRDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define RRDS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/rrds_pkg.sv */
// Shared constants and types for the round-robin delay task scheduler.
package rrds_pkg;

   localparam int TASK_COUNT = 4;
   localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int TICK_W     = 32;
   localparam int DELAY_W    = 32;
   localparam int SEL_W      = 2;
   localparam int MASK_W     = 4;

   localparam logic [IDX_W-1:0] LAST_TASK = IDX_W'(TASK_COUNT - 1);

   // task table operations
   typedef logic [1:0] tbl_op_type;
   localparam tbl_op_type TBL_NOP   = 2'd0;
   localparam tbl_op_type TBL_BLOCK = 2'd1;
   localparam tbl_op_type TBL_WAKE  = 2'd2;

   typedef struct packed {
      tbl_op_type         op;
      logic [IDX_W-1:0]   idx;
      logic [TICK_W-1:0]  wake_val;
   } tbl_ctrl_type;

endpackage

/* sv/rrds_if.sv */
// Valid/ready channel interfaces for scheduler events and results.
interface rrds_req_if;
   import rrds_pkg::*;

   logic               valid;
   logic               ready;
   logic               mode;
   logic [DELAY_W-1:0] delay_ticks;

   modport source (output valid, output mode, output delay_ticks, input ready);
   modport sink   (input valid, input mode, input delay_ticks, output ready);
endinterface

interface rrds_rsp_if;
   import rrds_pkg::*;

   logic              valid;
   logic              ready;
   logic [SEL_W-1:0]  selected_task;
   logic [TICK_W-1:0] tick_now;
   logic [MASK_W-1:0] ready_mask;

   modport source (output valid, output selected_task, output tick_now,
                   output ready_mask, input ready);
   modport sink   (input valid, input selected_task, input tick_now,
                   input ready_mask, output ready);
endinterface

/* sv/rrds_task_table.sv */
// Per-task blocked flags and wake times with one shared wake-time comparator.
module rrds_task_table (
   input  logic                              clock,
   input  logic                              reset,
   input  rrds_pkg::tbl_ctrl_type            ctrl,
   input  logic [rrds_pkg::TICK_W-1:0]       tick_now,
   output logic [rrds_pkg::TASK_COUNT-1:0]   blocked
);
   import rrds_pkg::*;

   logic [TICK_W-1:0]     wake_time_ff [TASK_COUNT];
   logic [TASK_COUNT-1:0] blocked_ff;
   logic [TASK_COUNT-1:0] blocked_in;
   logic                  due;

   // the one comparator, pointed at one task per cycle
   assign due = (tick_now >= wake_time_ff[ctrl.idx]);

   always_comb begin
      blocked_in = blocked_ff;
      case (ctrl.op)
         TBL_BLOCK: blocked_in[ctrl.idx] = 1'b1;
         TBL_WAKE: begin
            if (blocked_ff[ctrl.idx] && due) begin
               blocked_in[ctrl.idx] = 1'b0;
            end
         end
         default: blocked_in = blocked_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
      end else begin
         blocked_ff <= blocked_in;
      end
   end

   // wake times need no reset: read only once the task was blocked
   always_ff @(posedge clock) begin
      if (ctrl.op == TBL_BLOCK) begin
         wake_time_ff[ctrl.idx] <= ctrl.wake_val;
      end
   end

   assign blocked = blocked_ff;

endmodule

/* sv/round_robin_delay_task_scheduler_core.sv */
// Top level of the round-robin task scheduler with tick-based delays.
//
//  channel  | dir | payload                                  | transfer when
//  ---------+-----+------------------------------------------+----------------
//  req_bus  | in  | mode, delay_ticks                        | valid && ready
//  rsp_bus  | out | selected_task, tick_now, ready_mask      | valid && ready
//
// Tick event: accept in idle, a wake pass over every task, a scan of up to
// TASK_COUNT candidates, then the result state. A delay event skips the
// wake pass. Both loops run one task per cycle through the task table's
// single comparator and the scan pointer.
// Synchronous active-high reset: tick count 0, task 0 running, all ready.
// req ready is high only in idle; a finished result waits in the output
// register, so the next event is taken while rsp_bus is stalled.
`include "round_robin_delay_task_scheduler_core_assert.svh"

module round_robin_delay_task_scheduler_core (
   input  logic          clock,
   input  logic          reset,
   rrds_req_if.sink      req_bus,
   rrds_rsp_if.source    rsp_bus
);
   import rrds_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WAKE = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;         // step counter of both loops
   logic [IDX_W-1:0]      cand_ff, cand_in;       // scan candidate
   logic [IDX_W-1:0]      running_ff, running_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SEL_W-1:0]      rsp_sel_ff, rsp_sel_in;
   logic [TICK_W-1:0]     rsp_tick_ff, rsp_tick_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;

   logic                  req_fire;
   logic [TICK_W-1:0]     addend;
   logic [TICK_W-1:0]     sum;
   tbl_ctrl_type          tbl_ctrl;
   logic [TASK_COUNT-1:0] blocked;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] v);
      next_slot = (v == LAST_TASK) ? '0 : v + 1'b1;
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // single adder: tick + 1 for a tick, tick + delay for a delay request
   assign addend = req_bus.mode ? req_bus.delay_ticks : TICK_W'(1);
   assign sum    = tick_ff + addend;

   rrds_task_table u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tbl_ctrl),
      .tick_now (tick_ff),
      .blocked  (blocked)
   );

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      cand_in           = cand_ff;
      running_in        = running_ff;
      tick_in           = tick_ff;
      tbl_ctrl.op       = TBL_NOP;
      tbl_ctrl.idx      = cnt_ff;
      tbl_ctrl.wake_val = sum;
      rsp_valid_in      = rsp_valid_ff && !rsp_bus.ready;
      rsp_sel_in        = rsp_sel_ff;
      rsp_tick_in       = rsp_tick_ff;
      rsp_mask_in       = rsp_mask_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               if (!req_bus.mode) begin
                  tick_in  = sum;
                  state_in = ST_WAKE;
               end else begin
                  // block the running task; no wake pass for a delay
                  tbl_ctrl.op  = TBL_BLOCK;
                  tbl_ctrl.idx = running_ff;
                  cand_in      = next_slot(running_ff);
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_WAKE: begin
            // tick_ff already holds the new count here
            tbl_ctrl.op = TBL_WAKE;
            if (cnt_ff == LAST_TASK) begin
               cnt_in   = '0;
               cand_in  = next_slot(running_ff);
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            // scan ends on the running task itself; all blocked keeps it
            if (!blocked[cand_ff]) begin
               running_in = cand_ff;
               state_in   = ST_DONE;
            end else if (cnt_ff == LAST_TASK) begin
               state_in = ST_DONE;
            end else begin
               cand_in = next_slot(cand_ff);
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = SEL_W'(running_ff);
               rsp_tick_in  = tick_ff;
               rsp_mask_in  = MASK_W'(~blocked);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cand_ff      <= '0;
         running_ff   <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cand_ff      <= cand_in;
         running_ff   <= running_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sel_ff  <= rsp_sel_in;
      rsp_tick_ff <= rsp_tick_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.selected_task = rsp_sel_ff;
   assign rsp_bus.tick_now      = rsp_tick_ff;
   assign rsp_bus.ready_mask    = rsp_mask_ff;

   // an accepted event always starts the sequencer
   `RRDS_ASSERT_NEXT(a_fire_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE)
   // a tick event bumps the count by exactly one
   `RRDS_ASSERT_NEXT(a_tick_incr, clock, reset, req_fire && !req_bus.mode,
      tick_ff == $past(tick_ff) + TICK_W'(1))
   // the running task only moves at the end of a scan
   `RRDS_ASSERT_NEXT(a_running_hold, clock, reset, state_ff != ST_SCAN,
      running_ff == $past(running_ff))
   // a finished event is posted to the output register and the block goes idle
   `RRDS_ASSERT_NEXT(a_done_posts, clock, reset,
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready),
      rsp_valid_ff && state_ff == ST_IDLE)

endmodule
